@@ sv/terminal_key_escape_decoder_top_defines.svh @@
// assertion macros shared by the key decoder checker
`ifndef TERMINAL_KEY_ESCAPE_DECODER_TOP_DEFINES_SVH
`define TERMINAL_KEY_ESCAPE_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TKED_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define TKED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/tked_pkg.sv @@
// shared types and key codes of the terminal key decoder
package tked_pkg;

   // key classes
   localparam logic [1:0] CLASS_ASCII   = 2'd0;
   localparam logic [1:0] CLASS_NAMED   = 2'd1;
   localparam logic [1:0] CLASS_NUMPAD  = 2'd2;
   localparam logic [1:0] CLASS_CONTROL = 2'd3;

   // named key indices
   localparam logic [6:0] KEY_ESCAPE    = 7'd0;
   localparam logic [6:0] KEY_ENTER     = 7'd1;
   localparam logic [6:0] KEY_TAB       = 7'd2;
   localparam logic [6:0] KEY_BACKSPACE = 7'd3;
   localparam logic [6:0] KEY_ARROW0    = 7'd4;
   localparam logic [6:0] KEY_NAV0      = 7'd8;
   localparam logic [6:0] KEY_F1        = 7'd14;
   localparam logic [6:0] KEY_F5        = 7'd18;

   // one key event
   typedef struct packed {
      logic [1:0] key_class;
      logic [6:0] key_value;
   } event_type;

   // all events caused by one input byte, in order
   typedef struct packed {
      logic [1:0]      count;
      event_type [2:0] ev;
   } run_type;

endpackage

@@ sv/tked_front.sv @@
// front end: escape sequence parser that turns each byte into a run of events
module tked_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               chunk_end,
   output tked_pkg::run_type  run
);

   localparam logic [7:0] CHR_ESC     = 8'h1B;
   localparam logic [7:0] CHR_BRACKET = 8'h5B;
   localparam logic [7:0] CHR_O       = 8'h4F;
   localparam logic [7:0] CHR_TILDE   = 8'h7E;
   localparam logic [7:0] CHR_DEL     = 8'h7F;
   localparam logic [7:0] CHR_LF      = 8'h0A;
   localparam logic [7:0] CHR_CR      = 8'h0D;
   localparam logic [7:0] CHR_TAB     = 8'h09;
   localparam logic [7:0] CHR_SPACE   = 8'h20;

   typedef enum logic [2:0] {
      PH_GROUND = 3'd0,
      PH_ESC    = 3'd1,
      PH_CSI    = 3'd2,
      PH_SS3    = 3'd3,
      PH_DIGITS = 3'd4
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  acc_ff, acc_in;

   tked_pkg::event_type pl0, pl1, b0, b1;
   logic [1:0]  pl_n, body_n;
   logic        esc_pre, grd;
   logic        is_digit;
   logic [11:0] prod;
   logic [7:0]  acc_sat;

   assign is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);

   // accumulator times ten plus digit, saturating
   assign prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {8'h00, data_byte[3:0]};
   assign acc_sat = (prod > 12'd255) ? 8'hFF : prod[7:0];

   // plain byte mapping
   always_comb begin
      pl_n = 2'd0;
      pl0  = '0;
      pl1  = '0;
      if (data_byte == CHR_LF || data_byte == CHR_CR) begin
         pl_n = 2'd1;
         pl0  = '{tked_pkg::CLASS_NAMED, tked_pkg::KEY_ENTER};
      end else if (data_byte == CHR_TAB) begin
         pl_n = 2'd1;
         pl0  = '{tked_pkg::CLASS_NAMED, tked_pkg::KEY_TAB};
      end else if (data_byte == CHR_DEL) begin
         pl_n = 2'd1;
         pl0  = '{tked_pkg::CLASS_NAMED, tked_pkg::KEY_BACKSPACE};
      end else if (data_byte == CHR_SPACE) begin
         pl_n = 2'd1;
         pl0  = '{tked_pkg::CLASS_ASCII, data_byte[6:0]};
      end else if (data_byte >= 8'h61 && data_byte <= 8'h7A) begin
         pl_n = 2'd1;
         pl0  = '{tked_pkg::CLASS_ASCII, 7'(data_byte - 8'h20)};
      end else if (data_byte >= 8'h41 && data_byte <= 8'h5A) begin
         pl_n = 2'd1;
         pl0  = '{tked_pkg::CLASS_ASCII, data_byte[6:0]};
      end else if (is_digit) begin
         pl_n = 2'd2;
         pl0  = '{tked_pkg::CLASS_ASCII, data_byte[6:0]};
         pl1  = '{tked_pkg::CLASS_NUMPAD, {3'b000, data_byte[3:0]}};
      end else if (data_byte >= 8'h01 && data_byte <= 8'h1A) begin
         pl_n = 2'd2;
         pl0  = '{tked_pkg::CLASS_CONTROL, 7'd0};
         pl1  = '{tked_pkg::CLASS_ASCII, 7'(data_byte + 8'h40)};
      end
   end

   // phase machine and sequence events
   always_comb begin
      esc_pre  = 1'b0;
      grd      = 1'b0;
      body_n   = 2'd0;
      b0       = '0;
      b1       = '0;
      phase_in = PH_GROUND;
      acc_in   = acc_ff;
      case (phase_ff)
         PH_ESC: begin
            if (data_byte == CHR_BRACKET && !chunk_end) begin
               phase_in = PH_CSI;
            end else if (data_byte == CHR_O && !chunk_end) begin
               phase_in = PH_SS3;
            end else begin
               esc_pre = 1'b1;
               grd     = 1'b1;
            end
         end
         PH_CSI: begin
            if (data_byte >= 8'h41 && data_byte <= 8'h44) begin
               body_n = 2'd1;
               b0     = '{tked_pkg::CLASS_NAMED,
                          7'(tked_pkg::KEY_ARROW0 + data_byte - 8'h41)};
            end else if (is_digit) begin
               acc_in = {4'h0, data_byte[3:0]};
               if (!chunk_end) begin
                  phase_in = PH_DIGITS;
               end
            end
         end
         PH_SS3: begin
            if (data_byte >= 8'h50 && data_byte <= 8'h53) begin
               body_n = 2'd1;
               b0     = '{tked_pkg::CLASS_NAMED,
                          7'(tked_pkg::KEY_F1 + data_byte - 8'h50)};
            end
         end
         PH_DIGITS: begin
            if (is_digit) begin
               acc_in = acc_sat;
               if (!chunk_end) begin
                  phase_in = PH_DIGITS;
               end
            end else if (data_byte == CHR_TILDE) begin
               // navigation and upper function keys by number
               if (acc_ff >= 8'd1 && acc_ff <= 8'd6) begin
                  body_n = 2'd1;
                  b0 = '{tked_pkg::CLASS_NAMED, 7'(tked_pkg::KEY_NAV0 + acc_ff - 8'd1)};
               end else if (acc_ff == 8'd15) begin
                  body_n = 2'd1;
                  b0 = '{tked_pkg::CLASS_NAMED, tked_pkg::KEY_F5};
               end else if (acc_ff >= 8'd17 && acc_ff <= 8'd21) begin
                  body_n = 2'd1;
                  b0 = '{tked_pkg::CLASS_NAMED, 7'(tked_pkg::KEY_F5 + acc_ff - 8'd16)};
               end else if (acc_ff == 8'd23 || acc_ff == 8'd24) begin
                  body_n = 2'd1;
                  b0 = '{tked_pkg::CLASS_NAMED, 7'(tked_pkg::KEY_F5 + acc_ff - 8'd17)};
               end
            end else begin
               grd = 1'b1;
            end
         end
         default: begin
            grd = 1'b1;
         end
      endcase

      // ground phase handling, also for bytes given back by an aborted sequence
      if (grd) begin
         if (data_byte == CHR_ESC) begin
            if (chunk_end) begin
               body_n = 2'd1;
               b0     = '{tked_pkg::CLASS_NAMED, tked_pkg::KEY_ESCAPE};
            end else begin
               phase_in = PH_ESC;
            end
         end else begin
            body_n = pl_n;
            b0     = pl0;
            b1     = pl1;
         end
      end
   end

   // pack the run, lone escape first
   always_comb begin
      if (esc_pre) begin
         run.count = body_n + 2'd1;
         run.ev[0] = '{tked_pkg::CLASS_NAMED, tked_pkg::KEY_ESCAPE};
         run.ev[1] = b0;
         run.ev[2] = b1;
      end else begin
         run.count = body_n;
         run.ev[0] = b0;
         run.ev[1] = b1;
         run.ev[2] = '0;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_GROUND;
         acc_ff   <= 8'h00;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
      end
   end

endmodule

@@ sv/tked_fifo.sv @@
// short run queue between the parser and the event sequencer
module tked_fifo #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  tked_pkg::run_type  wr_data,
   output logic               is_full,
   input  logic               rd_en,
   output tked_pkg::run_type  rd_data,
   output logic               is_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   tked_pkg::run_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_wr, do_rd;

   assign is_full  = (count_ff == CNT_FULL);
   assign is_empty = (count_ff == '0);
   assign do_wr    = wr_en && !is_full;
   assign do_rd    = rd_en && !is_empty;
   assign rd_data  = slot_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ sv/tked_back.sv @@
// back end: plays out each queued run one event per cycle, while pop is high, into the result register
module tked_back (
   input  logic                 clock,
   input  logic                 reset,
   input  tked_pkg::run_type    head,
   input  logic                 head_empty,
   output logic                 head_pop,
   input  logic                 pop,
   output logic                 empty,
   output tked_pkg::event_type  rsp_event,
   output logic                 rsp_last
);

   logic                 valid_ff, valid_in;
   tked_pkg::event_type  ev_ff, ev_in;
   logic                 last_ff, last_in;
   logic [1:0]           sel_ff, sel_in;
   logic                 load;
   logic                 at_last;
   tked_pkg::event_type  pick;

   assign empty     = !valid_ff;
   assign rsp_event = ev_ff;
   assign rsp_last  = last_ff;
   assign load      = !valid_ff || pop;
   assign at_last   = (sel_ff == head.count - 2'd1);

   // event select within the head run
   always_comb begin
      case (sel_ff)
         2'd0:    pick = head.ev[0];
         2'd1:    pick = head.ev[1];
         2'd2:    pick = head.ev[2];
         default: pick = head.ev[0];
      endcase
   end

   // next output and run position
   always_comb begin
      valid_in = valid_ff;
      ev_in    = ev_ff;
      last_in  = last_ff;
      sel_in   = sel_ff;
      head_pop = 1'b0;
      if (load) begin
         valid_in = !head_empty;
         if (!head_empty) begin
            ev_in   = pick;
            last_in = at_last;
            if (at_last) begin
               head_pop = 1'b1;
               sel_in   = 2'd0;
            end else begin
               sel_in = sel_ff + 2'd1;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
      ev_ff   <= ev_in;
      last_ff <= last_in;
   end

endmodule

@@ sv/terminal_key_escape_decoder_top.sv @@
// terminal key decoder top level
// Input queue side: present req_data_byte and req_chunk_end with push high; the
// byte is taken at a rising edge where push is high and full is low. One byte
// can be taken every cycle while the run queue has room.
// Result queue side: while empty is low the oldest key event sits on
// rsp_key_class, rsp_key_value and rsp_last_of_run; pop high at that edge
// completes the transfer. rsp_last_of_run marks the final event of one byte.
// Each byte gives zero to three events. The first event of a byte passes through
// the run queue and then the result register; events then leave one per cycle
// while pop is high, so the number of events a byte produces in the sequencer
// sets the sustained rate.
// Bytes that produce no event never enter the queue.
// A stalled result side holds the shown event steady; the parser keeps taking
// bytes until QUEUE_DEPTH runs are waiting, then full rises.
// Reset (synchronous, active high) returns the parser to its ground phase,
// clears the digit accumulator and drops all queued events.
module terminal_key_escape_decoder_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_data_byte,
   input  logic       req_chunk_end,
   output logic       empty,
   input  logic       pop,
   output logic [1:0] rsp_key_class,
   output logic [6:0] rsp_key_value,
   output logic       rsp_last_of_run
);

   tked_pkg::run_type    run;
   tked_pkg::run_type    head;
   tked_pkg::event_type  rsp_event;
   logic                 accept;
   logic                 head_empty;
   logic                 head_pop;

   assign accept          = push && !full;
   assign rsp_key_class   = rsp_event.key_class;
   assign rsp_key_value   = rsp_event.key_value;

   // parser
   tked_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .chunk_end (req_chunk_end),
      .run       (run)
   );

   // run queue, only non-empty runs are written
   tked_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept && (run.count != 2'd0)),
      .wr_data  (run),
      .is_full  (full),
      .rd_en    (head_pop),
      .rd_data  (head),
      .is_empty (head_empty)
   );

   // event sequencer
   tked_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_empty (head_empty),
      .head_pop   (head_pop),
      .pop        (pop),
      .empty      (empty),
      .rsp_event  (rsp_event),
      .rsp_last   (rsp_last_of_run)
   );

endmodule

@@ sv/tked_checker.sv @@
// port-level checks of the terminal key decoder and their binding
`include "terminal_key_escape_decoder_top_defines.svh"

module tked_checker (
   input logic       clock,
   input logic       reset,
   input logic       empty,
   input logic       pop,
   input logic [1:0] rsp_key_class,
   input logic [6:0] rsp_key_value,
   input logic       rsp_last_of_run
);

   // a control modifier never closes its run, its letter follows
   `TKED_ASSERT_NOW(a_ctrl_not_last, clock, reset, !empty && rsp_key_class == tked_pkg::CLASS_CONTROL, !rsp_last_of_run, "control event closes a run")

   // a numpad digit always closes its run
   `TKED_ASSERT_NOW(a_numpad_last, clock, reset, !empty && rsp_key_class == tked_pkg::CLASS_NUMPAD, rsp_last_of_run, "numpad event not last of run")

   // the letter after control is shown in the very next cycle
   `TKED_ASSERT_NEXT(a_ctrl_letter, clock, reset, !empty && pop && rsp_key_class == tked_pkg::CLASS_CONTROL, !empty && rsp_key_class == tked_pkg::CLASS_ASCII, "control not followed by letter")

   // a stalled result holds
   `TKED_ASSERT_NEXT(a_stall_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_key_class) && $stable(rsp_key_value) && $stable(rsp_last_of_run), "stalled result changed")

endmodule

bind terminal_key_escape_decoder_top tked_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .empty           (empty),
   .pop             (pop),
   .rsp_key_class   (rsp_key_class),
   .rsp_key_value   (rsp_key_value),
   .rsp_last_of_run (rsp_last_of_run)
);

@@ verif/terminal_key_escape_decoder_top_test.sv @@
// self-checking testbench for the terminal key escape decoder
module terminal_key_escape_decoder_top_test;

   // byte codes used by the decoder
   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_DEL      = 8'h7F;
   localparam logic [7:0] CH_CTRL_LO  = 8'h01;
   localparam logic [7:0] CH_CTRL_HI  = 8'h1A;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_LBRACKET = "[";
   localparam logic [7:0] CH_SS3      = "O";
   localparam logic [7:0] CH_TILDE    = "~";
   localparam logic [7:0] CH_DIGIT0   = "0";
   localparam logic [7:0] CH_DIGIT9   = "9";
   localparam logic [7:0] CH_UPPER_A  = "A";
   localparam logic [7:0] CH_UPPER_D  = "D";
   localparam logic [7:0] CH_UPPER_Z  = "Z";
   localparam logic [7:0] CH_LOWER_A  = "a";
   localparam logic [7:0] CH_LOWER_Z  = "z";
   localparam logic [7:0] CH_UPPER_P  = "P";
   localparam logic [7:0] CH_UPPER_S  = "S";

   localparam int RANDOM_BYTES = 300;
   localparam int TAIL_CYCLES  = 20;
   localparam int HOLD_CYCLES  = 150;

   typedef enum logic [2:0] {
      PHASE_GROUND,
      PHASE_ESC,
      PHASE_CSI,
      PHASE_SS3,
      PHASE_DIGITS
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       chunk_end;
   } term_byte_type;

   typedef struct packed {
      logic [1:0] key_class;
      logic [6:0] key_value;
      logic       last_of_run;
   } key_event_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_chunk_end = 1'b0;
   logic       empty;
   logic       pop = 1'b0;
   logic [1:0] rsp_key_class;
   logic [6:0] rsp_key_value;
   logic       rsp_last_of_run;

   term_byte_type   pending_bytes[$];
   key_event_type   expected_keys[$];
   parse_phase_type decode_phase = PHASE_GROUND;
   logic [7:0]      digit_accum = 8'd0;
   int              keys_this_byte;
   int              total_bytes = 0;
   int              bytes_accepted = 0;
   int              keys_checked = 0;
   int              failures = 0;
   int              full_cycles = 0;
   int              holds_done = 0;

   terminal_key_escape_decoder_top DUT (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_data_byte   (req_data_byte),
      .req_chunk_end   (req_chunk_end),
      .empty           (empty),
      .pop             (pop),
      .rsp_key_class   (rsp_key_class),
      .rsp_key_value   (rsp_key_value),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------- key prediction ----------------

   task automatic add_key(input logic [1:0] cls, input int val);
      key_event_type k;
      k.key_class   = cls;
      k.key_value   = 7'(val);
      k.last_of_run = 1'b0;
      expected_keys = {expected_keys, k};
      keys_this_byte++;
   endtask

   // byte outside any escape sequence
   task automatic plain_key(input logic [7:0] c);
      if (c == CH_LF || c == CH_CR) begin
         add_key(tked_pkg::CLASS_NAMED, tked_pkg::KEY_ENTER);
      end else if (c == CH_TAB) begin
         add_key(tked_pkg::CLASS_NAMED, tked_pkg::KEY_TAB);
      end else if (c == CH_DEL) begin
         add_key(tked_pkg::CLASS_NAMED, tked_pkg::KEY_BACKSPACE);
      end else if (c == CH_SPACE) begin
         add_key(tked_pkg::CLASS_ASCII, c);
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         add_key(tked_pkg::CLASS_ASCII, c - CH_LOWER_A + CH_UPPER_A);
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         add_key(tked_pkg::CLASS_ASCII, c);
      end else if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
         add_key(tked_pkg::CLASS_ASCII, c);
         add_key(tked_pkg::CLASS_NUMPAD, c - CH_DIGIT0);
      end else if (c >= CH_CTRL_LO && c <= CH_CTRL_HI) begin
         add_key(tked_pkg::CLASS_CONTROL, 0);
         add_key(tked_pkg::CLASS_ASCII, CH_UPPER_A + c - CH_CTRL_LO);
      end
   endtask

   task automatic ground_key(input logic [7:0] c, input logic last_in_chunk);
      if (c == CH_ESC) begin
         if (last_in_chunk) add_key(tked_pkg::CLASS_NAMED, tked_pkg::KEY_ESCAPE);
         else decode_phase = PHASE_ESC;
      end else begin
         plain_key(c);
      end
   endtask

   // number collected between ESC [ and the tilde
   task automatic tilde_key(input int n);
      if (n >= 1 && n <= 6) begin
         add_key(tked_pkg::CLASS_NAMED, tked_pkg::KEY_NAV0 + n - 1);
      end else if (n == 15) begin
         add_key(tked_pkg::CLASS_NAMED, tked_pkg::KEY_F5);
      end else if (n >= 17 && n <= 21) begin
         add_key(tked_pkg::CLASS_NAMED, tked_pkg::KEY_F5 + 1 + n - 17);
      end else if (n == 23 || n == 24) begin
         add_key(tked_pkg::CLASS_NAMED, tked_pkg::KEY_F5 + 6 + n - 23);
      end
   endtask

   // work out the key events of one accepted byte
   task automatic decode_byte(input logic [7:0] c, input logic last_in_chunk);
      parse_phase_type ph;
      int              v;
      ph = decode_phase;
      keys_this_byte = 0;
      decode_phase = PHASE_GROUND;
      case (ph)
         PHASE_ESC: begin
            if (c == CH_LBRACKET && !last_in_chunk) begin
               decode_phase = PHASE_CSI;
            end else if (c == CH_SS3 && !last_in_chunk) begin
               decode_phase = PHASE_SS3;
            end else begin
               add_key(tked_pkg::CLASS_NAMED, tked_pkg::KEY_ESCAPE);
               ground_key(c, last_in_chunk);
            end
         end
         PHASE_CSI: begin
            if (c >= CH_UPPER_A && c <= CH_UPPER_D) begin
               add_key(tked_pkg::CLASS_NAMED, tked_pkg::KEY_ARROW0 + c - CH_UPPER_A);
            end else if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
               digit_accum = c - CH_DIGIT0;
               if (!last_in_chunk) decode_phase = PHASE_DIGITS;
            end
         end
         PHASE_SS3: begin
            if (c >= CH_UPPER_P && c <= CH_UPPER_S) begin
               add_key(tked_pkg::CLASS_NAMED, tked_pkg::KEY_F1 + c - CH_UPPER_P);
            end
         end
         PHASE_DIGITS: begin
            if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
               v = int'(digit_accum) * 10 + int'(c - CH_DIGIT0);
               digit_accum = (v > 255) ? 8'd255 : 8'(v);
               if (!last_in_chunk) decode_phase = PHASE_DIGITS;
            end else if (c == CH_TILDE) begin
               tilde_key(digit_accum);
            end else begin
               ground_key(c, last_in_chunk);
            end
         end
         default: begin
            ground_key(c, last_in_chunk);
         end
      endcase
      if (keys_this_byte > 0) expected_keys[expected_keys.size() - 1].last_of_run = 1'b1;
   endtask

   // ---------------- stimulus building ----------------

   task automatic add_byte(input logic [7:0] c, input logic last_in_chunk);
      term_byte_type b;
      b.data_byte = c;
      b.chunk_end = last_in_chunk;
      pending_bytes = {pending_bytes, b};
   endtask

   // ESC [ number ~ with an optional early chunk end or a wrong terminator
   task automatic add_number_sequence(input int n, input int flaw);
      string s;
      s = $sformatf("%0d", n);
      add_byte(CH_ESC, 1'b0);
      add_byte(CH_LBRACKET, 1'b0);
      for (int i = 0; i < s.len(); i++) begin
         add_byte(s[i], (flaw == 1) && (i == s.len() - 1));
      end
      if (flaw == 2) add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (flaw == 0) add_byte(CH_TILDE, 1'($urandom_range(0, 1)));
   endtask

   // one typed key from the common plain-byte groups
   function automatic logic [7:0] typed_byte();
      case ($urandom_range(0, 7))
         0: return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
         1: return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
         2: return 8'($urandom_range(CH_DIGIT0, CH_DIGIT9));
         3: return CH_SPACE;
         4: return $urandom_range(0, 1) ? CH_CR : CH_LF;
         5: return CH_TAB;
         6: return CH_DEL;
         default: return 8'($urandom_range(CH_CTRL_LO, CH_CTRL_HI));
      endcase
   endfunction

   task automatic add_random_sequence();
      int mapped[14] = '{1, 2, 3, 4, 5, 6, 15, 17, 18, 19, 20, 21, 23, 24};
      int n;
      case ($urandom_range(0, 9))
         0, 1: begin
            // raw noise bytes
            n = $urandom_range(1, 4);
            repeat (n) add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end
         2, 3: begin
            n = $urandom_range(1, 5);
            repeat (n) add_byte(typed_byte(), $urandom_range(0, 5) == 0);
         end
         4: begin
            add_byte(CH_ESC, 1'b0);
            add_byte(CH_LBRACKET, 1'b0);
            add_byte(8'($urandom_range(CH_UPPER_A, CH_UPPER_D)), 1'($urandom_range(0, 1)));
         end
         5: begin
            add_byte(CH_ESC, 1'b0);
            add_byte(CH_SS3, 1'b0);
            if ($urandom_range(0, 3) == 0) begin
               add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
               add_byte(8'($urandom_range(CH_UPPER_P, CH_UPPER_S)),
                        1'($urandom_range(0, 1)));
            end
         end
         6, 7: begin
            if ($urandom_range(0, 3) == 0) n = $urandom_range(0, 999);
            else n = mapped[$urandom_range(0, 13)];
            add_number_sequence(n, 0);
         end
         default: begin
            // broken or cut-short sequences
            case ($urandom_range(0, 6))
               0: begin
                  add_byte(CH_ESC, 1'b0);
                  add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               end
               1: add_byte(CH_ESC, 1'b1);
               2: begin
                  add_byte(CH_ESC, 1'b0);
                  add_byte($urandom_range(0, 1) ? CH_LBRACKET : CH_SS3, 1'b1);
               end
               3: add_number_sequence($urandom_range(0, 999), 1);
               4: add_number_sequence($urandom_range(0, 999), 2);
               5: begin
                  add_byte(CH_ESC, 1'b0);
                  add_byte(CH_LBRACKET, 1'b0);
                  add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               end
               default: begin
                  add_byte(CH_ESC, 1'b0);
                  add_byte(CH_ESC, 1'($urandom_range(0, 1)));
               end
            endcase
         end
      endcase
   endtask

   // ---------------- driver ----------------

   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      term_byte_type b;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            decode_byte(req_data_byte, req_chunk_end);
            bytes_accepted++;
         end
         if (push && full) begin
            // input stalled: hold the offered byte
            full_cycles++;
         end else if (gap_left > 0) begin
            gap_left--;
            push <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            b = pending_bytes.pop_front();
            push <= 1'b1;
            req_data_byte <= b.data_byte;
            req_chunk_end <= b.chunk_end;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
         end else begin
            push <= 1'b0;
         end
      end
   end

   // ---------------- monitor and receiver ----------------

   int rx_tick = 0;
   int rx_mode = 0;
   int hold_left = 0;
   int next_hold_at = 20;

   always @(posedge clock) begin
      key_event_type want;
      logic          take;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         // compare each transfer with the oldest prediction
         if (pop && !empty) begin
            keys_checked++;
            if (expected_keys.size() == 0) begin
               $error("unexpected key event class %0d value %0d", rsp_key_class, rsp_key_value);
               failures++;
            end else begin
               want = expected_keys.pop_front();
               if (rsp_key_class !== want.key_class) begin
                  $error("key_class: expected %0d, got %0d", want.key_class, rsp_key_class);
                  failures++;
               end
               if (rsp_key_value !== want.key_value) begin
                  $error("key_value: expected %0d, got %0d", want.key_value, rsp_key_value);
                  failures++;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0d, got %0d",
                         want.last_of_run, rsp_last_of_run);
                  failures++;
               end
            end
         end
         // stall pattern, with a long hold-off now and then
         rx_tick++;
         if (rx_tick % 50 == 0) rx_mode = $urandom_range(0, 2);
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else if (keys_checked >= next_hold_at) begin
            hold_left = HOLD_CYCLES;
            next_hold_at += 250;
            holds_done++;
            take = 1'b0;
         end else begin
            case (rx_mode)
               0: take = 1'b1;
               1: take = 1'($urandom_range(0, 1));
               default: take = (rx_tick % 4) != 0;
            endcase
         end
         pop <= take;
      end
   end

   // ---------------- sequence of the run ----------------

   initial begin
      // arrow, F4, F12, saturated unmapped number, lone escapes, a wrong terminator, plain bytes
      add_byte(CH_ESC, 1'b0); add_byte(CH_LBRACKET, 1'b0); add_byte(CH_UPPER_A, 1'b0);
      add_byte(CH_ESC, 1'b0); add_byte(CH_SS3, 1'b0); add_byte(CH_UPPER_S, 1'b1);
      add_number_sequence(24, 0);
      add_number_sequence(999, 0);
      add_byte(CH_ESC, 1'b1);
      add_byte(CH_ESC, 1'b0); add_byte(CH_LOWER_Z, 1'b0);
      add_number_sequence(7, 2);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b1);
      add_byte(CH_DEL, 1'b0);
      add_byte(CH_CTRL_LO, 1'b0);
      add_byte(CH_DIGIT9, 1'b1);
      n_directed: begin
         int directed;
         directed = pending_bytes.size();
         while (pending_bytes.size() < directed + RANDOM_BYTES) add_random_sequence();
      end
      total_bytes = pending_bytes.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (bytes_accepted < total_bytes) @(posedge clock);
      while (expected_keys.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d bytes, checked %0d key events", bytes_accepted, keys_checked);
      $display("receiver held off %0d times, input stalled by full on %0d cycles",
               holds_done, full_cycles);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #800000;
      $display("run did not finish in time, %0d key events outstanding", expected_keys.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/tked_pkg.sv
sv/tked_front.sv
sv/tked_fifo.sv
sv/tked_back.sv
sv/terminal_key_escape_decoder_top.sv
sv/tked_checker.sv
verif/terminal_key_escape_decoder_top_test.sv
